// ----- rtl/slip_frame_decoder_defines.svh -----
// Assertion macros shared by the SLIP frame decoder modules.
`ifndef SLIP_FRAME_DECODER_DEFINES_SVH
`define SLIP_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on clk_i, suspended while rst_ni is low.
`define SFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("slip_frame_decoder: assertion failed");
// Condition that must never be seen on clk_i outside reset.
`define SFD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("slip_frame_decoder: forbidden condition seen");
`else
`define SFD_ASSERT(label, prop)
`define SFD_ASSERT_NEVER(label, cond)
`endif

`endif

// ----- rtl/slip_fd_pkg.sv -----
// Types and constants of the SLIP frame decoder.
`timescale 1ns / 1ps
package slip_fd_pkg;

  localparam logic [7:0] BYTE_END     = 8'hC0;
  localparam logic [7:0] BYTE_ESC     = 8'hDB;
  localparam logic [7:0] BYTE_ESC_END = 8'hDC;
  localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

  localparam int unsigned LEN_WIDTH = 16;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOF  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           data_byte;
    logic                 escape_error;
    logic [LEN_WIDTH-1:0] frame_length;
  } token_t;

endpackage

// ----- rtl/slip_fd_front.sv -----
// Front end: accepts line bytes, tracks escape state and frame length, emits tokens.
`timescale 1ns / 1ps
`include "slip_frame_decoder_defines.svh"
module slip_fd_front #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                q_full_i,
  output logic                push_o,
  output slip_fd_pkg::token_t push_tok_o
);
  import slip_fd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] LEN_SAT = COUNT_WIDTH'(LEN_MAX);

  logic                   esc_q, esc_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   accept;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [LEN_WIDTH-1:0]   len_sat;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // hold at all ones once the counter saturates
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
  assign len_sat = (cnt_q > LEN_SAT) ? LEN_MAX : LEN_WIDTH'(cnt_q);

  always_comb begin
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    push_o     = 1'b0;
    push_tok_o = '{kind: KIND_DATA, data_byte: in_byte_i, escape_error: 1'b0,
                   frame_length: '0};
    if (accept) begin
      priority if (esc_q) begin
        // consume the escaped byte whatever it is
        esc_d  = 1'b0;
        cnt_d  = cnt_inc;
        push_o = 1'b1;
        if (in_byte_i == BYTE_ESC_END) begin
          push_tok_o.data_byte = BYTE_END;
        end else begin
          push_tok_o.data_byte    = BYTE_ESC;
          push_tok_o.escape_error = (in_byte_i != BYTE_ESC_ESC);
        end
      end else if (in_byte_i == BYTE_ESC) begin
        esc_d = 1'b1;
      end else if (in_byte_i == BYTE_END) begin
        // drop empty frames
        cnt_d                   = '0;
        push_o                  = (cnt_q != '0);
        push_tok_o.kind         = KIND_EOF;
        push_tok_o.data_byte    = '0;
        push_tok_o.frame_length = len_sat;
      end else begin
        cnt_d  = cnt_inc;
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      esc_q <= esc_d;
      cnt_q <= cnt_d;
    end
  end

  `SFD_ASSERT(a_esc_arms, accept && !esc_q && in_byte_i == BYTE_ESC |=> esc_q)
  `SFD_ASSERT(a_end_clears, accept && !esc_q && in_byte_i == BYTE_END |=> cnt_q == '0)
  `SFD_ASSERT(a_eof_nonzero, push_o && push_tok_o.kind == KIND_EOF |-> cnt_q != '0)

endmodule

// ----- rtl/slip_fd_queue.sv -----
// Short token queue between the front end and the output stage.
`timescale 1ns / 1ps
`include "slip_frame_decoder_defines.svh"
module slip_fd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  slip_fd_pkg::token_t push_tok_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output slip_fd_pkg::token_t pop_tok_o
);
  import slip_fd_pkg::*;

  token_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_q, wr_d;
  logic [QPTR_WIDTH-1:0] rd_q, rd_d;
  logic [QCNT_WIDTH-1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == QCNT_WIDTH'(QUEUE_DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign pop_tok_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_WIDTH'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_WIDTH'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_WIDTH'(1);
      2'b01:   cnt_d = cnt_q - QCNT_WIDTH'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `SFD_ASSERT_NEVER(a_push_full, push_i && full_o)
  `SFD_ASSERT_NEVER(a_pop_empty, pop_i && !valid_o)
  `SFD_ASSERT_NEVER(a_cnt_range, cnt_q > QCNT_WIDTH'(QUEUE_DEPTH))

endmodule

// ----- rtl/slip_fd_back.sv -----
// Output stage: registers one token and presents it on the result channel.
`timescale 1ns / 1ps
module slip_fd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  slip_fd_pkg::token_t q_tok_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slip_fd_pkg::token_t out_tok_o
);
  import slip_fd_pkg::*;

  logic   vld_q, vld_d;
  token_t tok_q;

  // advance when the register is empty or its transaction completes
  assign pop_o = q_valid_i && (!vld_q || out_ready_i);
  assign vld_d = pop_o ? 1'b1 : (vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tok_q <= q_tok_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_tok_o   = tok_q;

endmodule

// ----- rtl/slip_frame_decoder.sv -----
// Top level of the SLIP receive-side frame decoder.
//
// Decodes a SLIP byte stream at one byte per clock: a byte is taken on every cycle in which
// the two-entry token queue is not full, and a result passes through the queue and the output
// register to out_valid_o. ESC bytes and empty frames produce no result; END of a non-empty
// frame gives kind_o = 1 with the data byte count, saturating at 2**COUNT_WIDTH-1 and shown
// clamped to 16 bits. The front end (escape flag and frame counter) and the output register
// stall independently; back-pressure reaches in_ready_o only once the queue is full.
`timescale 1ns / 1ps
module slip_frame_decoder #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic        escape_error_o,
  output logic [15:0] frame_length_o
);
  import slip_fd_pkg::*;

  logic   q_full;
  logic   push;
  token_t push_tok;
  logic   pop;
  logic   q_valid;
  token_t q_tok;
  token_t out_tok;

  slip_fd_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_tok_o (push_tok)
  );

  slip_fd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_tok_o  (q_tok)
  );

  slip_fd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_tok_i     (q_tok),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_tok_o   (out_tok)
  );

  assign kind_o         = out_tok.kind;
  assign data_byte_o    = out_tok.data_byte;
  assign escape_error_o = out_tok.escape_error;
  assign frame_length_o = out_tok.frame_length;

endmodule

// ----- tb/slip_frame_decoder_checker.sv -----
// Scoreboard for the SLIP frame decoder: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module slip_frame_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        escape_error_i,
  input  logic [15:0] frame_length_i,
  output int unsigned pending_o,
  output int unsigned errors_o,
  output int unsigned checked_o
);
  import slip_fd_pkg::*;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic                   esc_armed   = 1'b0;
  logic [COUNT_WIDTH-1:0] frame_bytes = '0;
  token_t                 expected_tokens[$];
  int unsigned            mismatches  = 0;
  int unsigned            checked     = 0;

  function automatic void count_data_byte();
    if (frame_bytes != COUNT_MAX) frame_bytes = frame_bytes + 1'b1;
  endfunction

  // Advance the decoder state by one line byte; return 1 when a token comes out.
  function automatic bit decode_line_byte(input logic [7:0] b, output token_t tok);
    tok = '0;
    tok.kind = KIND_DATA;
    if (esc_armed) begin
      // The byte after ESC is always consumed, END and ESC included.
      esc_armed = 1'b0;
      case (b)
        BYTE_ESC_END: tok.data_byte = BYTE_END;
        BYTE_ESC_ESC: tok.data_byte = BYTE_ESC;
        default: begin
          tok.data_byte    = BYTE_ESC;
          tok.escape_error = 1'b1;
        end
      endcase
      count_data_byte();
      return 1'b1;
    end
    if (b == BYTE_ESC) begin
      esc_armed = 1'b1;
      return 1'b0;
    end
    if (b == BYTE_END) begin
      // Drop empty frames.
      if (frame_bytes == '0) return 1'b0;
      tok.kind         = KIND_EOF;
      tok.frame_length = (frame_bytes > LEN_MAX) ? LEN_MAX : LEN_WIDTH'(frame_bytes);
      frame_bytes      = '0;
      return 1'b1;
    end
    tok.data_byte = b;
    count_data_byte();
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : monitor
    token_t want;
    if (!rst_ni) begin
      esc_armed   = 1'b0;
      frame_bytes = '0;
      expected_tokens.delete();
    end else begin
      // Check the output transaction first: it can only belong to an earlier byte.
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result: kind %0d data_byte 0x%02h escape_error %0d length %0d",
                 kind_i, data_byte_i, escape_error_i, frame_length_i);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          checked++;
          if (kind_i !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind_i);
            mismatches++;
          end
          if (data_byte_i !== want.data_byte) begin
            $error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte, data_byte_i);
            mismatches++;
          end
          if (escape_error_i !== want.escape_error) begin
            $error("escape_error: expected %0d, got %0d", want.escape_error, escape_error_i);
            mismatches++;
          end
          if (frame_length_i !== want.frame_length) begin
            $error("frame_length: expected %0d, got %0d", want.frame_length, frame_length_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (decode_line_byte(in_byte_i, want)) expected_tokens.push_back(want);
      end
    end
    pending_o <= expected_tokens.size();
    errors_o  <= mismatches;
    checked_o <= checked;
  end

endmodule

// ----- tb/slip_frame_decoder_tb.sv -----
// Testbench top for the SLIP frame decoder: line byte stimulus, output back-pressure, verdict.
`timescale 1ns / 1ps
module slip_frame_decoder_tb;
  import slip_fd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CALM_TAIL    = 300;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LONG_FRAME   = 200;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        kind_o;
  logic [7:0]  data_byte_o;
  logic        escape_error_o;
  logic [15:0] frame_length_o;

  int unsigned pending;
  int unsigned errors;
  int unsigned checked;

  bit          tx_gaps_on    = 1'b0;
  bit          rx_gaps_on    = 1'b0;
  int unsigned hold_req_cnt  = 0;
  int unsigned hold_done_cnt = 0;
  int unsigned bytes_sent    = 0;
  int unsigned frames_sent   = 0;
  int unsigned cycles        = 0;

  slip_frame_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .escape_error_o (escape_error_o),
    .frame_length_o (frame_length_o)
  );

  slip_frame_decoder_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_i         (kind_o),
    .data_byte_i    (data_byte_o),
    .escape_error_i (escape_error_o),
    .frame_length_i (frame_length_o),
    .pending_o      (pending),
    .errors_o       (errors),
    .checked_o      (checked)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("FAIL slip_frame_decoder");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin : receiver
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req_cnt != hold_done_cnt) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done_cnt++;
      end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one line byte and hold it until the transaction completes.
  task automatic send_byte(input logic [7:0] b);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // Stop offering and wait until every predicted result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One frame: mostly plain data and proper escapes, some bad escapes, then END (at times twice).
  task automatic send_frame(input int unsigned units);
    int unsigned r;
    for (int unsigned i = 0; i < units; i++) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (r < 86) begin
        send_byte(BYTE_ESC);
        send_byte(r[0] ? BYTE_ESC_END : BYTE_ESC_ESC);
      end else if (r < 94) begin
        send_byte(BYTE_ESC);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(r[0] ? BYTE_ESC_END : BYTE_ESC_ESC);
      end
    end
    send_byte(BYTE_END);
    if ($urandom_range(0, 5) == 0) send_byte(BYTE_END);
    frames_sent++;
  endtask

  initial begin : stimulus
    logic [7:0]  opening[$] = '{
      BYTE_END, 8'h00, 8'hFF, 8'hA5, 8'h5A,
      BYTE_ESC, BYTE_ESC_END, BYTE_ESC, BYTE_ESC_ESC,
      BYTE_ESC, BYTE_END, BYTE_ESC, BYTE_ESC, BYTE_ESC, 8'h3C,
      BYTE_ESC_END, BYTE_ESC_ESC, BYTE_END, BYTE_END, 8'h01, BYTE_ESC
    };
    int unsigned random_start;
    int unsigned done;
    int unsigned r;
    logic [7:0]  b;
    bit          hold_started = 1'b0;
    bit          mid_drained  = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_byte(opening[i]);
    // Leave the escape armed across an idle stretch, then resolve it as a bad escape.
    drain();
    send_byte(8'h7E);
    send_byte(BYTE_END);
    drain();

    random_start = bytes_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (!hold_started && done >= 600) begin
        hold_started = 1'b1;
        hold_req_cnt++;
      end
      if (!mid_drained && done >= 1200) begin
        mid_drained = 1'b1;
        drain();
      end
      if (done >= RANDOM_ITEMS - CALM_TAIL) begin
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
      end else begin
        tx_gaps_on = ($urandom_range(0, 5) != 0);
        rx_gaps_on = ($urandom_range(0, 5) != 0);
      end
      r = $urandom_range(0, 19);
      send_frame((r == 0) ? 0 : (r == 1) ? $urandom_range(40, 120) : $urandom_range(1, 16));
      done = bytes_sent - random_start;
    end

    // Send one long plain frame, then check the count restarts from zero.
    for (int unsigned i = 0; i < LONG_FRAME; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == BYTE_END || b == BYTE_ESC) b = b ^ 8'h01;
      send_byte(b);
    end
    send_byte(BYTE_END);
    frames_sent++;
    send_frame(3);

    drain();
    repeat (SETTLE) @(posedge clk_i);

    $display("Sent %0d line bytes in %0d frames, %0d results checked", bytes_sent, frames_sent,
             checked);
    $display("Mix: escapes good and bad, empty frames, output hold-off, a %0d-byte frame",
             LONG_FRAME);
    if (errors == 0 && pending == 0) begin
      $display("PASS slip_frame_decoder");
    end else begin
      $display("FAIL slip_frame_decoder");
    end
    $finish;
  end

endmodule
